@@ design/erd_pkg.sv @@
// Shared package for the escaped record deframer.
// Holds framing byte codes and the record type passed between stages.
// No dependencies.
package erd_pkg;

    localparam logic [7:0] DELIM_BYTE   = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE  = 8'h7D;
    localparam logic [7:0] ESCAPE_XOR   = 8'h20;
    // Payload bytes stored before the last byte of a record arrives
    localparam int unsigned GATHER_BYTES = 6;
    localparam logic [2:0] LAST_POS     = 3'd6;

    typedef struct packed {
        logic        [15:0] transaction_id;
        logic        [7:0]  operation;
        logic        [15:0] target_address;
        logic signed [15:0] data_value;
    } t_record;

endpackage

@@ design/erd_in_stage.sv @@
// Input register stage of the escaped record deframer.
// Holds one received byte until the unstuffing stage consumes it.
// Depends on nothing outside this file.
module erd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output logic       o_held_valid,
    output logic [7:0] o_held_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;

    // Take a new byte whenever the slot is empty or being drained
    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_advance) begin
            n_valid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_held_valid = r_valid;
    assign o_held_byte  = r_byte;

endmodule

@@ design/erd_unstuff.sv @@
// Byte unstuffing and record assembly for the escaped record deframer.
// Tracks escape state and payload position, stores six payload bytes.
// Depends on erd_pkg.
module erd_unstuff (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_advance,
    output logic            o_emit,
    output erd_pkg::t_record o_record
);

    logic       r_escape;
    logic [2:0] r_pos;
    logic [7:0] r_gathered [erd_pkg::GATHER_BYTES];

    logic       n_escape;
    logic [2:0] n_pos;
    logic       is_delim;
    logic       is_escape;
    logic       is_payload;
    logic [7:0] payload_byte;

    // Classify the held byte and undo the escape
    assign is_delim     = (i_byte == erd_pkg::DELIM_BYTE);
    assign is_escape    = (i_byte == erd_pkg::ESCAPE_BYTE);
    assign is_payload   = !is_delim && !is_escape;
    assign payload_byte = r_escape ? (i_byte ^ erd_pkg::ESCAPE_XOR) : i_byte;

    // A record completes on the seventh payload byte
    assign o_emit = i_valid && is_payload && (r_pos == erd_pkg::LAST_POS);

    assign o_record.transaction_id = {r_gathered[1], r_gathered[0]};
    assign o_record.operation      = r_gathered[2];
    assign o_record.target_address = {r_gathered[4], r_gathered[3]};
    assign o_record.data_value     = $signed({payload_byte, r_gathered[5]});

    // Next escape flag and position
    always_comb begin
        n_escape = r_escape;
        n_pos    = r_pos;
        if (is_delim) begin
            n_escape = 1'b0;
            n_pos    = 3'd0;
        end else if (is_escape) begin
            n_escape = 1'b1;
        end else begin
            n_escape = 1'b0;
            if (r_pos == erd_pkg::LAST_POS) begin
                n_pos = 3'd0;
            end else begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= 1'b0;
            r_pos    <= 3'd0;
        end else if (i_advance) begin
            r_escape <= n_escape;
            r_pos    <= n_pos;
        end
    end

    // Store payload bytes 0 to 5 at the current position
    always_ff @(posedge i_clk) begin
        if (i_advance && is_payload && (r_pos != erd_pkg::LAST_POS)) begin
            r_gathered[r_pos] <= payload_byte;
        end
    end

endmodule

@@ design/erd_out_stage.sv @@
// Output register of the escaped record deframer.
// Holds one finished record until the downstream side takes it.
// Depends on erd_pkg.
module erd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  erd_pkg::t_record i_record,
    input  logic             i_ready,
    output logic             o_valid,
    output erd_pkg::t_record o_record
);

    logic             r_valid;
    erd_pkg::t_record r_record;

    // Load a new record or drop the one just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_record <= i_record;
        end
    end

    assign o_valid  = r_valid;
    assign o_record = r_record;

endmodule

@@ design/escaped_record_deframer.sv @@
// Escaped record deframer: accepts one raw byte per cycle while o_ready is
// high and returns one record per seven payload bytes, with 0x7E delimiters
// dropped (restarting the record) and 0x7D escapes removed. A byte is
// registered on entry in the input register, unstuffed from there and, when
// it completes a record, loaded into the output register, which presents
// the record until it is taken. The single input register feeds the single
// output register; input ready drops only while a finished record waits in
// the output register and the held byte would complete another one.
module escaped_record_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_transaction_id,
    output logic [7:0]         o_operation,
    output logic [15:0]        o_target_address,
    output logic signed [15:0] o_data_value
);

    logic             held_valid;
    logic [7:0]       held_byte;
    logic             advance;
    logic             emit;
    erd_pkg::t_record record;
    erd_pkg::t_record out_record;

    // Advance the held byte unless its record has nowhere to go
    assign advance = held_valid && (!emit || !o_valid || i_ready);

    erd_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_byte       (i_rx_byte),
        .i_advance    (advance),
        .o_held_valid (held_valid),
        .o_held_byte  (held_byte)
    );

    erd_unstuff u_unstuff (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (held_valid),
        .i_byte    (held_byte),
        .i_advance (advance),
        .o_emit    (emit),
        .o_record  (record)
    );

    erd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_record (record),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_record (out_record)
    );

    assign o_transaction_id = out_record.transaction_id;
    assign o_operation      = out_record.operation;
    assign o_target_address = out_record.target_address;
    assign o_data_value     = out_record.data_value;

endmodule

@@ design/erd_checker.sv @@
// Port-level checker for the escaped record deframer.
// Watches only top-level ports; bound to escaped_record_deframer below.
// Depends on nothing outside this file.
module erd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_transaction_id,
    input logic [7:0]  o_operation,
    input logic [15:0] o_target_address,
    input logic [15:0] o_data_value
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A stalled record holds its payload
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_transaction_id)
            && $stable(o_operation) && $stable(o_target_address)
            && $stable(o_data_value)))
        else $error("stalled record changed");

    // Input backpressure only comes from a blocked full output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without output backpressure");

    // A fresh record needs a byte taken by the input stage before it
    a_record_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("record appeared without an input transaction");

endmodule

bind escaped_record_deframer erd_checker u_erd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_transaction_id (o_transaction_id),
    .o_operation      (o_operation),
    .o_target_address (o_target_address),
    .o_data_value     (o_data_value)
);

@@ verif/tb_escaped_record_deframer.sv @@
// Testbench for escaped_record_deframer: drives raw serial bytes, predicts
// the unstuffed seven-byte records and checks every returned record in order.
// Depends on erd_pkg and the escaped_record_deframer RTL.
`timescale 1ns / 100ps

module tb_escaped_record_deframer;

    localparam int IDLE_PCT       = 14;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Track unstuffing state and hold the records still owed by the block
    class record_ledger;
        bit       esc_armed;
        bit [2:0] fill;
        bit [47:0] held;
        erd_pkg::t_record records_due[$];
        int       mismatches;

        task flag_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // Advance the deframing state by one accepted byte
        task take_byte(logic [7:0] raw);
            logic [7:0]       b;
            erd_pkg::t_record rec;
            b = raw;
            if (b == erd_pkg::DELIM_BYTE) begin
                esc_armed = 1'b0;
                fill      = '0;
            end else if (b == erd_pkg::ESCAPE_BYTE) begin
                esc_armed = 1'b1;
            end else begin
                if (esc_armed) begin
                    b         = b ^ erd_pkg::ESCAPE_XOR;
                    esc_armed = 1'b0;
                end
                if (fill < erd_pkg::LAST_POS) begin
                    held[8*fill +: 8] = b;
                    fill = fill + 3'd1;
                end else begin
                    rec.transaction_id = held[15:0];
                    rec.operation      = held[23:16];
                    rec.target_address = held[39:24];
                    rec.data_value     = {b, held[47:40]};
                    records_due.push_back(rec);
                    fill = '0;
                end
            end
        endtask

        // Compare a returned record with the oldest one owed
        task match_record(erd_pkg::t_record got);
            erd_pkg::t_record want;
            if (records_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected record id=%h op=%h addr=%h data=%h",
                    got.transaction_id, got.operation, got.target_address,
                    got.data_value));
                return;
            end
            want = records_due.pop_front();
            if (got.transaction_id !== want.transaction_id)
                flag_mismatch($sformatf("transaction_id got %h want %h",
                    got.transaction_id, want.transaction_id));
            if (got.operation !== want.operation)
                flag_mismatch($sformatf("operation got %h want %h",
                    got.operation, want.operation));
            if (got.target_address !== want.target_address)
                flag_mismatch($sformatf("target_address got %h want %h",
                    got.target_address, want.target_address));
            if (got.data_value !== want.data_value)
                flag_mismatch($sformatf("data_value got %0d want %0d",
                    got.data_value, want.data_value));
        endtask
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_rx_byte = '0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [15:0]        o_transaction_id;
    logic [7:0]         o_operation;
    logic [15:0]        o_target_address;
    logic signed [15:0] o_data_value;

    record_ledger ledger;
    bit           calm = 1'b0;
    int           bytes_sent = 0;
    int           quiet_cycles = 0;
    logic [7:0]   directed_bytes[$];

    escaped_record_deframer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_transaction_id (o_transaction_id),
        .o_operation      (o_operation),
        .o_target_address (o_target_address),
        .o_data_value     (o_data_value)
    );

    always #10 i_clk = ~i_clk;

    // Stall the record side at random and check each accepted record
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            ledger.match_record(erd_pkg::t_record'{o_transaction_id, o_operation,
                                                   o_target_address, o_data_value});
        i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** escaped_record_deframer: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one byte, idling first at random, and hold it until accepted
    task automatic send_byte(logic [7:0] b);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        ledger.take_byte(b);
        bytes_sent++;
    endtask

    // Hold off the byte side until every owed record has come back
    task automatic wait_for_records();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.records_due.size() != 0);
    endtask

    // Payload values biased toward framing codes and extremes
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(7))
            0:       return erd_pkg::DELIM_BYTE;
            1:       return erd_pkg::ESCAPE_BYTE;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Stuff one payload byte: escape the codes and sometimes any byte
    task automatic send_payload(logic [7:0] b);
        if (b == erd_pkg::DELIM_BYTE || b == erd_pkg::ESCAPE_BYTE
                || $urandom_range(9) == 0) begin
            send_byte(erd_pkg::ESCAPE_BYTE);
            send_byte(b ^ erd_pkg::ESCAPE_XOR);
        end else begin
            send_byte(b);
        end
    endtask

    // Well-formed frame holding one to three back-to-back records
    task automatic send_frame();
        int n_records;
        n_records = $urandom_range(1, 3);
        send_byte(erd_pkg::DELIM_BYTE);
        repeat (7 * n_records) send_payload(pick_payload());
    endtask

    // Truncated frame, sometimes cut by an escape followed by a delimiter
    task automatic send_broken_frame();
        send_byte(erd_pkg::DELIM_BYTE);
        repeat ($urandom_range(0, 6)) send_payload(pick_payload());
        if ($urandom_range(1) == 0)
            send_byte(erd_pkg::ESCAPE_BYTE);
        if ($urandom_range(1) == 0)
            send_byte(erd_pkg::ESCAPE_BYTE);
        send_byte(erd_pkg::DELIM_BYTE);
    endtask

    initial begin
        int pick;
        bit paused;
        ledger = new();
        paused = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, escaped codes, double escape, escape cut by
        // delimiter, partial record discarded, most negative data value
        directed_bytes = '{erd_pkg::DELIM_BYTE, 8'h00, 8'hFF,
                           erd_pkg::ESCAPE_BYTE,
                           erd_pkg::DELIM_BYTE ^ erd_pkg::ESCAPE_XOR,
                           erd_pkg::ESCAPE_BYTE,
                           erd_pkg::ESCAPE_BYTE ^ erd_pkg::ESCAPE_XOR,
                           8'h80, 8'h7F, 8'h01,
                           erd_pkg::ESCAPE_BYTE, erd_pkg::ESCAPE_BYTE, 8'h0A, 8'h11,
                           erd_pkg::ESCAPE_BYTE, erd_pkg::DELIM_BYTE,
                           8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80};
        foreach (directed_bytes[k])
            send_byte(directed_bytes[k]);
        bytes_sent = 0;

        // Random: mostly framed records, some truncation and raw noise
        while (bytes_sent < RANDOM_ITEMS) begin
            calm = (bytes_sent >= 400 && bytes_sent < 600);
            if (!paused && bytes_sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                wait_for_records();
            end
            pick = $urandom_range(99);
            if (pick < 75)
                send_frame();
            else if (pick < 88)
                send_broken_frame();
            else
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
        end
        calm = 1'b0;

        // Drain the remaining records, then let the pipeline settle
        i_valid <= 1'b0;
        while (ledger.records_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.mismatches == 0)
            $display("** escaped_record_deframer: PASSED **");
        else
            $display("** escaped_record_deframer: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
design/erd_pkg.sv
design/erd_in_stage.sv
design/erd_unstuff.sv
design/erd_out_stage.sv
design/escaped_record_deframer.sv
design/erd_checker.sv
verif/tb_escaped_record_deframer.sv
